// ----- rtl/cpt_pkg.sv -----
// Shared types and constants for the closest-point-on-triangle block.
// Used by the front end, the queue, the back end and the top level.
package cpt_pkg;

  localparam int CW    = 32;   // coordinate width, signed Q16.16
  localparam int PW    = 66;   // one term of a dot product
  localparam int DOTW  = 68;   // a full dot product
  localparam int HW    = 34;   // half of a dot product for split multiplies
  localparam int VW    = 138;  // products of dot products and their sums
  localparam int QB    = 16;   // quotient bits of an interpolation parameter
  localparam int WW    = 17;   // weight width, unsigned Q1.16
  localparam int MW    = 51;   // weight times edge vector
  localparam int RW    = 36;   // rounded offset
  localparam int IN_W  = 384;
  localparam int OUT_W = 136;

  localparam logic [WW-1:0] ONE_Q16 = 17'h10000;

  // Operand pairs for the six products of dot products:
  // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

  typedef enum logic [2:0] {
    REG_VERT_A,
    REG_VERT_B,
    REG_VERT_C,
    REG_EDGE_AB,
    REG_EDGE_AC,
    REG_EDGE_BC,
    REG_INTERIOR
  } region_t;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [CW:0]     diff_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [VW-1:0]   wide_t;

  // One classified request handed from the front end to the back end.
  typedef struct packed {
    logic [2:0][CW-1:0] base;
    logic [2:0][CW:0]   dir_a;
    logic [2:0][CW:0]   dir_b;
    logic [VW-1:0]      num0;
    logic [VW-1:0]      num1;
    logic [VW-1:0]      den;
    logic               zero0;
    logic               full0;
    logic               zero1;
    logic               full1;
    region_t            region;
    logic               degen;
  } cpt_item_t;

endpackage

// ----- rtl/cpt_front.sv -----
// Front end: takes requests, forms the dot products exactly and classifies
// the region. Depends on cpt_pkg.
module cpt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cpt_pkg::IN_W-1:0]  in_tdata,
  output logic                      item_valid,
  input  logic                      item_ready,
  output cpt_pkg::cpt_item_t        item
);
  import cpt_pkg::*;

  localparam int NST = 9;

  logic [NST-1:0] vld_r;
  logic           en;

  coord_t p1_r [3], a1_r [3], b1_r [3], c1_r [3];
  coord_t a2_r [3], b2_r [3], c2_r [3];
  diff_t  ab2_r [3], ac2_r [3], bc2_r [3], ap2_r [3], bp2_r [3], cp2_r [3];
  coord_t a3_r [3], b3_r [3], c3_r [3];
  diff_t  ab3_r [3], ac3_r [3], bc3_r [3];
  logic signed [PW-1:0] pr3_r [6][3];
  coord_t a4_r [3], b4_r [3], c4_r [3];
  diff_t  ab4_r [3], ac4_r [3], bc4_r [3];
  dot_t   d4_r [6];
  coord_t a5_r [3], b5_r [3], c5_r [3];
  diff_t  ab5_r [3], ac5_r [3], bc5_r [3];
  dot_t   d5_r [6];
  logic signed [2*HW-1:0] hh5_r [6];
  logic signed [2*HW:0]   hl5_r [6], lh5_r [6];
  logic [2*HW-1:0]        ll5_r [6];
  coord_t a6_r [3], b6_r [3], c6_r [3];
  diff_t  ab6_r [3], ac6_r [3], bc6_r [3];
  dot_t   d6_r [6];
  wide_t  pd6_r [6];
  coord_t a7_r [3], b7_r [3], c7_r [3];
  diff_t  ab7_r [3], ac7_r [3], bc7_r [3];
  dot_t   d7_r [6];
  wide_t  va7_r, vb7_r, vc7_r;

  region_t reg8_r, reg8_nxt;
  wide_t   num0_8_r, num1_8_r, den8_r, num0_8_nxt, num1_8_nxt, den8_nxt;
  coord_t  a8_r [3], base8_r [3], base8_nxt [3];
  diff_t   dira8_r [3], dirb8_r [3], dira8_nxt [3], dirb8_nxt [3];
  wide_t   e43, e56;

  logic       degen9;
  cpt_item_t  item_r;

  assign en         = !vld_r[NST-1] || item_ready;
  assign in_tready  = en;
  assign item_valid = vld_r[NST-1];
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Stages one to seven: unpack, differences, products, dot products and
  // the exact products of dot products, split into 34-bit halves.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= in_tdata[i*CW +: CW];
        a1_r[i] <= in_tdata[(3+i)*CW +: CW];
        b1_r[i] <= in_tdata[(6+i)*CW +: CW];
        c1_r[i] <= in_tdata[(9+i)*CW +: CW];

        a2_r[i]  <= a1_r[i];
        b2_r[i]  <= b1_r[i];
        c2_r[i]  <= c1_r[i];
        ab2_r[i] <= diff_t'(b1_r[i]) - diff_t'(a1_r[i]);
        ac2_r[i] <= diff_t'(c1_r[i]) - diff_t'(a1_r[i]);
        bc2_r[i] <= diff_t'(c1_r[i]) - diff_t'(b1_r[i]);
        ap2_r[i] <= diff_t'(p1_r[i]) - diff_t'(a1_r[i]);
        bp2_r[i] <= diff_t'(p1_r[i]) - diff_t'(b1_r[i]);
        cp2_r[i] <= diff_t'(p1_r[i]) - diff_t'(c1_r[i]);

        a3_r[i]  <= a2_r[i];
        b3_r[i]  <= b2_r[i];
        c3_r[i]  <= c2_r[i];
        ab3_r[i] <= ab2_r[i];
        ac3_r[i] <= ac2_r[i];
        bc3_r[i] <= bc2_r[i];
        pr3_r[0][i] <= ab2_r[i] * ap2_r[i];
        pr3_r[1][i] <= ac2_r[i] * ap2_r[i];
        pr3_r[2][i] <= ab2_r[i] * bp2_r[i];
        pr3_r[3][i] <= ac2_r[i] * bp2_r[i];
        pr3_r[4][i] <= ab2_r[i] * cp2_r[i];
        pr3_r[5][i] <= ac2_r[i] * cp2_r[i];

        a4_r[i]  <= a3_r[i];
        b4_r[i]  <= b3_r[i];
        c4_r[i]  <= c3_r[i];
        ab4_r[i] <= ab3_r[i];
        ac4_r[i] <= ac3_r[i];
        bc4_r[i] <= bc3_r[i];

        a5_r[i]  <= a4_r[i];
        b5_r[i]  <= b4_r[i];
        c5_r[i]  <= c4_r[i];
        ab5_r[i] <= ab4_r[i];
        ac5_r[i] <= ac4_r[i];
        bc5_r[i] <= bc4_r[i];

        a6_r[i]  <= a5_r[i];
        b6_r[i]  <= b5_r[i];
        c6_r[i]  <= c5_r[i];
        ab6_r[i] <= ab5_r[i];
        ac6_r[i] <= ac5_r[i];
        bc6_r[i] <= bc5_r[i];

        a7_r[i]  <= a6_r[i];
        b7_r[i]  <= b6_r[i];
        c7_r[i]  <= c6_r[i];
        ab7_r[i] <= ab6_r[i];
        ac7_r[i] <= ac6_r[i];
        bc7_r[i] <= bc6_r[i];
      end
      for (int k = 0; k < 6; k++) begin
        d4_r[k] <= DOTW'(pr3_r[k][0]) + DOTW'(pr3_r[k][1]) + DOTW'(pr3_r[k][2]);
        d5_r[k] <= d4_r[k];
        d6_r[k] <= d5_r[k];
        d7_r[k] <= d6_r[k];
        hh5_r[k] <= $signed(d4_r[PX[k]][DOTW-1:HW]) * $signed(d4_r[PY[k]][DOTW-1:HW]);
        hl5_r[k] <= $signed(d4_r[PX[k]][DOTW-1:HW]) * $signed({1'b0, d4_r[PY[k]][HW-1:0]});
        lh5_r[k] <= $signed({1'b0, d4_r[PX[k]][HW-1:0]}) * $signed(d4_r[PY[k]][DOTW-1:HW]);
        ll5_r[k] <= d4_r[PX[k]][HW-1:0] * d4_r[PY[k]][HW-1:0];
        pd6_r[k] <= (VW'(hh5_r[k]) << (2*HW)) + ((VW'(hl5_r[k]) + VW'(lh5_r[k])) << HW)
                    + VW'(ll5_r[k]);
      end
      vc7_r <= pd6_r[0] - pd6_r[1];
      vb7_r <= pd6_r[2] - pd6_r[3];
      va7_r <= pd6_r[4] - pd6_r[5];
    end
  end

  // Stage eight: region tests in priority order.
  always_comb begin
    e43        = wide_t'(d7_r[3]) - wide_t'(d7_r[2]);
    e56        = wide_t'(d7_r[4]) - wide_t'(d7_r[5]);
    reg8_nxt   = REG_INTERIOR;
    num0_8_nxt = vb7_r;
    num1_8_nxt = '0;
    den8_nxt   = va7_r + vb7_r + vc7_r;
    for (int i = 0; i < 3; i++) begin
      base8_nxt[i] = a7_r[i];
      dira8_nxt[i] = ab7_r[i];
      dirb8_nxt[i] = ac7_r[i];
    end
    if (d7_r[0] <= 0 && d7_r[1] <= 0) begin
      reg8_nxt   = REG_VERT_A;
      num0_8_nxt = '0;
    end else if (d7_r[2] >= 0 && d7_r[3] <= d7_r[2]) begin
      reg8_nxt   = REG_VERT_B;
      num0_8_nxt = '0;
      for (int i = 0; i < 3; i++) base8_nxt[i] = b7_r[i];
    end else if (d7_r[5] >= 0 && d7_r[4] <= d7_r[5]) begin
      reg8_nxt   = REG_VERT_C;
      num0_8_nxt = '0;
      for (int i = 0; i < 3; i++) base8_nxt[i] = c7_r[i];
    end else if (vc7_r <= 0 && d7_r[0] >= 0 && d7_r[2] <= 0) begin
      reg8_nxt   = REG_EDGE_AB;
      num0_8_nxt = wide_t'(d7_r[0]);
      den8_nxt   = wide_t'(d7_r[0]) - wide_t'(d7_r[2]);
    end else if (vb7_r <= 0 && d7_r[1] >= 0 && d7_r[5] <= 0) begin
      reg8_nxt   = REG_EDGE_AC;
      num0_8_nxt = wide_t'(d7_r[1]);
      den8_nxt   = wide_t'(d7_r[1]) - wide_t'(d7_r[5]);
      for (int i = 0; i < 3; i++) dira8_nxt[i] = ac7_r[i];
    end else if (va7_r <= 0 && e43 >= 0 && e56 >= 0) begin
      reg8_nxt   = REG_EDGE_BC;
      num0_8_nxt = e43;
      den8_nxt   = e43 + e56;
      for (int i = 0; i < 3; i++) begin
        base8_nxt[i] = b7_r[i];
        dira8_nxt[i] = bc7_r[i];
      end
    end else begin
      num1_8_nxt = vc7_r;
    end
  end

  // Stage nine: degenerate check and the early-out flags of both quotients.
  assign degen9 = (reg8_r inside {REG_EDGE_AB, REG_EDGE_AC, REG_EDGE_BC, REG_INTERIOR})
                  && den8_r <= 0;

  always_ff @(posedge clk) begin
    if (en) begin
      reg8_r   <= reg8_nxt;
      num0_8_r <= num0_8_nxt;
      num1_8_r <= num1_8_nxt;
      den8_r   <= den8_nxt;
      for (int i = 0; i < 3; i++) begin
        a8_r[i]    <= a7_r[i];
        base8_r[i] <= base8_nxt[i];
        dira8_r[i] <= dira8_nxt[i];
        dirb8_r[i] <= dirb8_nxt[i];
      end

      for (int i = 0; i < 3; i++) begin
        item_r.base[i]  <= degen9 ? a8_r[i] : base8_r[i];
        item_r.dir_a[i] <= dira8_r[i];
        item_r.dir_b[i] <= dirb8_r[i];
      end
      item_r.num0   <= num0_8_r;
      item_r.num1   <= num1_8_r;
      item_r.den    <= den8_r;
      item_r.zero0  <= degen9 || num0_8_r <= 0;
      item_r.full0  <= num0_8_r >= den8_r;
      item_r.zero1  <= degen9 || num1_8_r <= 0;
      item_r.full1  <= num1_8_r >= den8_r;
      item_r.region <= reg8_r;
      item_r.degen  <= degen9;
    end
  end

endmodule

// ----- rtl/cpt_queue.sv -----
// Short queue of classified requests between the front and back ends.
// Depends on cpt_pkg for the entry type.
module cpt_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cpt_pkg::cpt_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cpt_pkg::cpt_item_t pop_item
);
  import cpt_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cpt_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = cnt_r != CNTW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// ----- rtl/cpt_back.sv -----
// Back end: two pipelined restoring dividers for the interpolation
// parameters, then weights, point placement and the output register.
// Depends on cpt_pkg.
module cpt_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  cpt_pkg::cpt_item_t        item,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cpt_pkg::OUT_W-1:0] out_tdata
);
  import cpt_pkg::*;

  localparam int NB = QB + 4;

  logic [NB-1:0] vld_r;
  logic          en;

  cpt_item_t     itm_r  [QB+1];
  logic [VW:0]   rem0_r [QB+1];
  logic [VW:0]   rem1_r [QB+1];
  logic [QB-1:0] q0_r   [QB+1];
  logic [QB-1:0] q1_r   [QB+1];

  logic [WW-1:0]        s0, s1, wa_nxt, wb_nxt;
  logic signed [WW+1:0] swa;
  region_t              region_p;
  logic                 degen_p;

  coord_t                base1_r [3], base2_r [3];
  logic signed [MW-1:0]  m0_r [3], m1_r [3];
  logic signed [MW:0]    tsum [3];
  logic signed [RW-1:0]  rnd2_r [3];
  logic signed [CW+5:0]  placed [3];
  logic [WW-1:0]         wa1_r, wb1_r, wa2_r, wb2_r;
  region_t               reg1_r, reg2_r;
  logic                  degen1_r, degen2_r;

  coord_t        near_r [3];
  logic [WW-1:0] wa_r, wb_r;
  region_t       reg_r;
  logic          degen_r;

  assign en         = !vld_r[NB-1] || out_tready;
  assign item_ready = en;
  assign out_tvalid = vld_r[NB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_r[0]  <= item;
      rem0_r[0] <= {1'b0, item.num0};
      rem1_r[0] <= {1'b0, item.num1};
      q0_r[0]   <= '0;
      q1_r[0]   <= '0;
    end
  end

  // One quotient bit per stage and lane.
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [VW+1:0] sh0, sh1;
    logic          ge0, ge1;

    assign sh0 = {rem0_r[k-1], 1'b0};
    assign sh1 = {rem1_r[k-1], 1'b0};
    assign ge0 = sh0 >= {2'b00, itm_r[k-1].den};
    assign ge1 = sh1 >= {2'b00, itm_r[k-1].den};

    always_ff @(posedge clk) begin
      if (en) begin
        itm_r[k]  <= itm_r[k-1];
        rem0_r[k] <= ge0 ? (VW+1)'(sh0 - {2'b00, itm_r[k-1].den}) : sh0[VW:0];
        rem1_r[k] <= ge1 ? (VW+1)'(sh1 - {2'b00, itm_r[k-1].den}) : sh1[VW:0];
        q0_r[k]   <= {q0_r[k-1][QB-2:0], ge0};
        q1_r[k]   <= {q1_r[k-1][QB-2:0], ge1};
      end
    end
  end

  // Clamped quotients and the weights for each region.
  always_comb begin
    region_p = itm_r[QB].region;
    degen_p  = itm_r[QB].degen;
    s0 = itm_r[QB].zero0 ? '0 : (itm_r[QB].full0 ? ONE_Q16 : {1'b0, q0_r[QB]});
    s1 = itm_r[QB].zero1 ? '0 : (itm_r[QB].full1 ? ONE_Q16 : {1'b0, q1_r[QB]});
    swa    = (WW+2)'(ONE_Q16) - (WW+2)'(s0) - (WW+2)'(s1);
    wa_nxt = ONE_Q16;
    wb_nxt = '0;
    case (region_p)
      REG_VERT_A: begin
        wa_nxt = ONE_Q16;
        wb_nxt = '0;
      end
      REG_VERT_B: begin
        wa_nxt = '0;
        wb_nxt = ONE_Q16;
      end
      REG_VERT_C: begin
        wa_nxt = '0;
        wb_nxt = '0;
      end
      REG_EDGE_AB: begin
        wa_nxt = ONE_Q16 - s0;
        wb_nxt = s0;
      end
      REG_EDGE_AC: begin
        wa_nxt = ONE_Q16 - s0;
        wb_nxt = '0;
      end
      REG_EDGE_BC: begin
        wa_nxt = '0;
        wb_nxt = ONE_Q16 - s0;
      end
      REG_INTERIOR: begin
        if (swa[WW+1]) begin
          // Weight of a went negative: give the shortfall to the larger one.
          wa_nxt = '0;
          wb_nxt = (s0 > s1) ? WW'((WW+2)'(s0) + swa) : s0;
        end else begin
          wa_nxt = swa[WW-1:0];
          wb_nxt = s0;
        end
      end
      default: begin
        wa_nxt = ONE_Q16;
        wb_nxt = '0;
      end
    endcase
    if (degen_p) begin
      wa_nxt = ONE_Q16;
      wb_nxt = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i]   = (MW+1)'(m0_r[i]) + (MW+1)'(m1_r[i]) + (MW+1)'(32768);
      placed[i] = (CW+6)'(base2_r[i]) + (CW+6)'(rnd2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        base1_r[i] <= $signed(itm_r[QB].base[i]);
        m0_r[i]    <= $signed({1'b0, s0}) * $signed(itm_r[QB].dir_a[i]);
        m1_r[i]    <= $signed({1'b0, s1}) * $signed(itm_r[QB].dir_b[i]);

        base2_r[i] <= base1_r[i];
        rnd2_r[i]  <= tsum[i][MW:MW+1-RW];

        if (placed[i] > (CW+6)'(64'sd2147483647)) begin
          near_r[i] <= coord_t'(32'h7fffffff);
        end else if (placed[i] < -(CW+6)'(64'sd2147483648)) begin
          near_r[i] <= coord_t'(32'h80000000);
        end else begin
          near_r[i] <= placed[i][CW-1:0];
        end
      end
      wa1_r    <= wa_nxt;
      wb1_r    <= wb_nxt;
      reg1_r   <= region_p;
      degen1_r <= degen_p;
      wa2_r    <= wa1_r;
      wb2_r    <= wb1_r;
      reg2_r   <= reg1_r;
      degen2_r <= degen1_r;
      wa_r     <= wa2_r;
      wb_r     <= wb2_r;
      reg_r    <= reg2_r;
      degen_r  <= degen2_r;
    end
  end

  assign out_tdata = {2'b00, degen_r, reg_r, wb_r, wa_r, near_r[2], near_r[1], near_r[0]};

endmodule

// ----- rtl/closest_point_on_triangle.sv -----
// Top level of the closest-point-on-triangle block: front end, request
// queue and back end. Depends on cpt_pkg, cpt_front, cpt_queue, cpt_back.
//
// Channel | Role   | tdata bits | Fields, lowest bit first
// in_*    | slave  | 384        | query x,y,z; vert_a x,y,z; vert_b x,y,z; vert_c x,y,z
// out_*   | master | 136        | near x,y,z; weight_a; weight_b; region; degenerate
//
// One request is taken per cycle while the front end is not stalled, and every
// request passes through the front end, the queue and the back end in turn.
// The back end's length comes from the two sixteen-stage dividers.
// Reset is synchronous and active low and empties every stage and the queue.
// A stalled output holds the back end; the front end keeps taking requests
// until the queue of QUEUE_DEPTH entries is full and an item waits at its output.
module closest_point_on_triangle #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [cpt_pkg::IN_W-1:0]  in_tdata,   // query x,y,z, a x,y,z, b x,y,z, c x,y,z
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [cpt_pkg::OUT_W-1:0] out_tdata   // near x,y,z, weight_a, weight_b,
                                                // region, degenerate, zero fill
);
  import cpt_pkg::*;

  cpt_item_t front_item, back_item;
  logic      front_valid, front_ready, back_valid, back_ready;

  logic [WW-1:0] out_wa, out_wb;
  logic [2:0]    out_region;
  logic          out_degen;

  cpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  cpt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  cpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign out_wa     = out_tdata[3*CW +: WW];
  assign out_wb     = out_tdata[3*CW+WW +: WW];
  assign out_region = out_tdata[3*CW+2*WW +: 3];
  assign out_degen  = out_tdata[3*CW+2*WW+3];

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_wa} + {1'b0, out_wb}) <= {1'b0, ONE_Q16})
    else $error("weights of a and b add up to more than one");

  a_degen_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_degen |-> out_wa == ONE_Q16 && out_wb == '0
      && (out_region == REG_EDGE_AB || out_region == REG_EDGE_AC
          || out_region == REG_EDGE_BC || out_region == REG_INTERIOR))
    else $error("degenerate result is not vertex a in an edge or interior region");

  a_vertex_c: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_region == REG_VERT_C |-> out_wa == '0 && out_wb == '0 && !out_degen)
    else $error("vertex c result carries weights or the degenerate flag");

endmodule
